// ===== hdl/three_phase_rms_monitor_macros.svh =====
// Assertion macros shared by the RMS monitor checker.
`ifndef THREE_PHASE_RMS_MONITOR_MACROS_SVH
`define THREE_PHASE_RMS_MONITOR_MACROS_SVH

// Concurrent assertion sampled on clk_i and disabled while rst_ni is low.
`define RTPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion sampled on clk_i that also holds during reset.
`define RTPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/rtpm_pkg.sv =====
// Types and constants shared by the three-phase RMS monitor.
package rtpm_pkg;

  // Channel count and channel index width.
  localparam int CHANNELS = 3;
  localparam int CH_W     = 2;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  // Widths of the register fields and of the internal words.
  localparam int WLEN_W   = 10;
  localparam int OFFS_W   = 12;
  localparam int WORD_W   = 16;
  localparam int SMP_W    = 16;
  localparam int SQ_W     = 2 * SMP_W;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 11;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = SUM_W + FRAC_W;
  localparam int REM_W    = CNT_W + 1;
  localparam int ROOT_W   = QUO_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int PROD_W   = ROOT_W + WORD_W;
  localparam int RND_W    = PROD_W + 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = QUO_W / 2;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;

  // Command queue depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 3'd0,
    CFG_ADC_OFFSET = 3'd1,
    CFG_VOLT_SCALE = 3'd2,
    CFG_MIN_RMS    = 3'd3,
    CFG_REV_LOW    = 3'd4,
    CFG_REV_HIGH   = 3'd5
  } cfg_idx_e;

  // Configuration register set.
  typedef struct packed {
    logic [WLEN_W-1:0] window_len;
    logic [OFFS_W-1:0] adc_offset;
    logic [WORD_W-1:0] volt_scale;
    logic [WORD_W-1:0] min_rms;
    logic [WORD_W-1:0] rev_low;
    logic [WORD_W-1:0] rev_high;
  } cfg_t;

  // One classified tick, handed from the front end to the back end.
  typedef struct packed {
    logic                            close;
    logic [CHANNELS-1:0]             acc;
    logic [CHANNELS-1:0][SMP_W-1:0]  smp;
    logic                            rev;
  } cmd_t;

  // Request to the RMS calculation unit.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } calc_req_t;

  // Answer of the RMS calculation unit.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] rms;
  } calc_rsp_t;

endpackage

// ===== hdl/rtpm_in_if.sv =====
// Input channel: one timer tick with three samples and a phase count.
interface rtpm_in_if #(
  parameter int ADC_BITS = 12
) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample_r;
  logic [ADC_BITS-1:0] sample_y;
  logic [ADC_BITS-1:0] sample_b;
  logic [15:0]         phase_count;

  modport source (output valid, sample_r, sample_y, sample_b, phase_count, input ready);
  modport sink   (input valid, sample_r, sample_y, sample_b, phase_count, output ready);
endinterface

// ===== hdl/rtpm_out_if.sv =====
// Output channel: RMS values, loss flags, reversal and window flags.
interface rtpm_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] rms_r;
  logic [15:0] rms_y;
  logic [15:0] rms_b;
  logic        loss_r;
  logic        loss_y;
  logic        loss_b;
  logic        reversal;
  logic        window_done;

  modport source (output valid, rms_r, rms_y, rms_b, loss_r, loss_y, loss_b,
                  reversal, window_done, input ready);
  modport sink   (input valid, rms_r, rms_y, rms_b, loss_r, loss_y, loss_b,
                  reversal, window_done, output ready);
endinterface

// ===== hdl/rtpm_front.sv =====
// Front end: accepts ticks, runs the window counter and classifies each tick.
module rtpm_front #(
  parameter int ADC_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtpm_pkg::cfg_t cfg_i,
  rtpm_in_if.sink        in_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output rtpm_pkg::cmd_t push_data_o
);

  logic [rtpm_pkg::CNT_W-1:0] tick_q, tick_d;
  logic [rtpm_pkg::CNT_W-1:0] tick_nx;
  logic                       close;
  logic                       accept;
  logic [rtpm_pkg::CHANNELS-1:0][rtpm_pkg::SMP_W-1:0] smp;

  // A word is taken whenever the queue has room.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // Samples are cut to the converter width and widened to the internal width.
  assign smp[0] = rtpm_pkg::SMP_W'(in_i.sample_r[ADC_BITS-1:0]);
  assign smp[1] = rtpm_pkg::SMP_W'(in_i.sample_y[ADC_BITS-1:0]);
  assign smp[2] = rtpm_pkg::SMP_W'(in_i.sample_b[ADC_BITS-1:0]);

  // The tick that takes the counter past the window length closes the window.
  assign tick_nx = tick_q + rtpm_pkg::CNT_W'(1);
  assign close   = tick_nx > rtpm_pkg::CNT_W'(cfg_i.window_len);

  always_comb begin
    push_data_o.close = close;
    push_data_o.smp   = smp;
    push_data_o.rev   = !((in_i.phase_count > cfg_i.rev_low) &&
                          (in_i.phase_count < cfg_i.rev_high));
    for (int c = 0; c < rtpm_pkg::CHANNELS; c++) begin
      push_data_o.acc[c] = !close && (smp[c] > rtpm_pkg::SMP_W'(cfg_i.adc_offset));
    end
  end

  // Tick counter advances on each accepted word and restarts on a close.
  always_comb begin
    tick_d = tick_q;
    if (accept) begin
      tick_d = close ? '0 : tick_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else begin
      tick_q <= tick_d;
    end
  end

endmodule

// ===== hdl/rtpm_queue.sv =====
// Short command queue between the front and back ends.
module rtpm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rtpm_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rtpm_pkg::cmd_t pop_data_o
);

  rtpm_pkg::cmd_t              mem_q [rtpm_pkg::QUEUE_DEPTH];
  logic [rtpm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [rtpm_pkg::QCNT_W-1:0] count_q;
  logic                        push, pop;

  assign push_ready_o = count_q != rtpm_pkg::QCNT_W'(rtpm_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + rtpm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + rtpm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + rtpm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - rtpm_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/rtpm_calc.sv =====
// RMS unit: long division, bit-serial square root, scaling and saturation.
module rtpm_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rtpm_pkg::WORD_W-1:0] volt_scale_i,
  input  rtpm_pkg::calc_req_t         req_i,
  output rtpm_pkg::calc_rsp_t         rsp_o
);

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV,
    C_SQRT,
    C_MUL,
    C_RND
  } calc_state_e;

  calc_state_e                  state_q;
  logic [rtpm_pkg::STEP_W-1:0]  step_q;
  logic [rtpm_pkg::QUO_W-1:0]   dq_q;
  logic [rtpm_pkg::REM_W-1:0]   rem_q;
  logic [rtpm_pkg::CNT_W-1:0]   div_q;
  logic [rtpm_pkg::SREM_W-1:0]  srem_q;
  logic [rtpm_pkg::ROOT_W-1:0]  root_q;
  logic [rtpm_pkg::PROD_W-1:0]  prod_q;
  logic                         done_q;
  logic [rtpm_pkg::WORD_W-1:0]  rms_q;

  logic [rtpm_pkg::REM_W-1:0]   rem_sh;
  logic                         div_ge;
  logic [rtpm_pkg::SREM_W-1:0]  srem_sh;
  logic [rtpm_pkg::SREM_W-1:0]  trial;
  logic                         sqrt_ge;
  logic [rtpm_pkg::RND_W-1:0]   rnd;

  // One quotient bit per cycle: shift in the next dividend bit, try to subtract.
  assign rem_sh = {rem_q[rtpm_pkg::CNT_W-1:0], dq_q[rtpm_pkg::QUO_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_q};

  // One root bit per cycle: bring down two bits, try root*4+1.
  assign srem_sh = {srem_q[rtpm_pkg::SREM_W-3:0], dq_q[rtpm_pkg::QUO_W-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign sqrt_ge = srem_sh >= trial;

  // Round to nearest on the 16 fraction bits of the scaled root.
  assign rnd = rtpm_pkg::RND_W'(prod_q) + rtpm_pkg::RND_W'(32768);

  assign rsp_o.done = done_q;
  assign rsp_o.rms  = rms_q;

  // Done pulse: an empty channel answers at once, any other after rounding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ((state_q == C_IDLE) && req_i.start && (req_i.cnt == '0)) ||
                (state_q == C_RND);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      rms_q   <= '0;
      dq_q    <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      srem_q  <= '0;
      root_q  <= '0;
      prod_q  <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            if (req_i.cnt == '0) begin
              // An empty channel reads as zero volts.
              rms_q   <= '0;
            end else begin
              dq_q    <= {req_i.sum, rtpm_pkg::FRAC_W'(0)};
              div_q   <= req_i.cnt;
              rem_q   <= '0;
              step_q  <= '0;
              state_q <= C_DIV;
            end
          end
        end
        C_DIV: begin
          dq_q   <= {dq_q[rtpm_pkg::QUO_W-2:0], div_ge};
          rem_q  <= div_ge ? rem_sh - {1'b0, div_q} : rem_sh;
          if (step_q == rtpm_pkg::STEP_W'(rtpm_pkg::DIV_STEPS - 1)) begin
            step_q  <= '0;
            srem_q  <= '0;
            root_q  <= '0;
            state_q <= C_SQRT;
          end else begin
            step_q  <= step_q + rtpm_pkg::STEP_W'(1);
          end
        end
        C_SQRT: begin
          dq_q   <= {dq_q[rtpm_pkg::QUO_W-3:0], 2'b00};
          srem_q <= sqrt_ge ? srem_sh - trial : srem_sh;
          root_q <= {root_q[rtpm_pkg::ROOT_W-2:0], sqrt_ge};
          if (step_q == rtpm_pkg::STEP_W'(rtpm_pkg::SQRT_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= C_MUL;
          end else begin
            step_q  <= step_q + rtpm_pkg::STEP_W'(1);
          end
        end
        C_MUL: begin
          prod_q  <= root_q * volt_scale_i;
          state_q <= C_RND;
        end
        C_RND: begin
          // Saturate anything beyond sixteen integer bits.
          rms_q   <= (|rnd[rtpm_pkg::RND_W-1:2*rtpm_pkg::WORD_W]) ?
                     '1 : rnd[2*rtpm_pkg::WORD_W-1:rtpm_pkg::WORD_W];
          state_q <= C_IDLE;
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rtpm_back.sv =====
// Back end: accumulates squares, closes windows and drives the result register.
module rtpm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtpm_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  rtpm_pkg::cmd_t      cmd_i,
  output rtpm_pkg::calc_req_t calc_req_o,
  input  rtpm_pkg::calc_rsp_t calc_rsp_i,
  rtpm_out_if.source          out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ADD,
    ST_CSTART,
    ST_CWAIT,
    ST_OUT
  } back_state_e;

  back_state_e                  state_q;
  logic [rtpm_pkg::CH_W-1:0]    ch_q;
  rtpm_pkg::cmd_t               cmd_q;
  logic [rtpm_pkg::SQ_W-1:0]    prod_q;
  logic [rtpm_pkg::SUM_W-1:0]   sum_q  [rtpm_pkg::CHANNELS];
  logic [rtpm_pkg::CNT_W-1:0]   cnt_q  [rtpm_pkg::CHANNELS];
  logic [rtpm_pkg::WORD_W-1:0]  rms_q  [rtpm_pkg::CHANNELS];
  logic [rtpm_pkg::CHANNELS-1:0] loss_q;

  logic                          out_valid_q;
  logic [rtpm_pkg::WORD_W-1:0]   out_rms_q [rtpm_pkg::CHANNELS];
  logic [rtpm_pkg::CHANNELS-1:0] out_loss_q;
  logic                          out_rev_q;
  logic                          out_done_q;

  logic [rtpm_pkg::SUM_W:0]     sum_ext;
  logic [rtpm_pkg::SUM_W-1:0]   sum_sat;

  // New commands are taken only between items.
  assign cmd_ready_o = state_q == ST_IDLE;

  // Saturating square sum of the channel in hand.
  assign sum_ext = {1'b0, sum_q[ch_q]} + (rtpm_pkg::SUM_W + 1)'(prod_q);
  assign sum_sat = sum_ext[rtpm_pkg::SUM_W] ? '1 : sum_ext[rtpm_pkg::SUM_W-1:0];

  // Calculation request for the channel in hand.
  assign calc_req_o.start = state_q == ST_CSTART;
  assign calc_req_o.sum   = sum_q[ch_q];
  assign calc_req_o.cnt   = cnt_q[ch_q];

  // Result register.
  assign out_o.valid       = out_valid_q;
  assign out_o.rms_r       = out_rms_q[0];
  assign out_o.rms_y       = out_rms_q[1];
  assign out_o.rms_b       = out_rms_q[2];
  assign out_o.loss_r      = out_loss_q[0];
  assign out_o.loss_y      = out_loss_q[1];
  assign out_o.loss_b      = out_loss_q[2];
  assign out_o.reversal    = out_rev_q;
  assign out_o.window_done = out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      cmd_q       <= '0;
      prod_q      <= '0;
      loss_q      <= '0;
      out_valid_q <= 1'b0;
      out_loss_q  <= '0;
      out_rev_q   <= 1'b0;
      out_done_q  <= 1'b0;
      for (int c = 0; c < rtpm_pkg::CHANNELS; c++) begin
        sum_q[c]     <= '0;
        cnt_q[c]     <= '0;
        rms_q[c]     <= '0;
        out_rms_q[c] <= '0;
      end
    end else begin
      // The result word leaves when the receiver takes it.
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            ch_q  <= '0;
            if (cmd_i.close) begin
              // Loss flags come from the RMS values of the window before.
              for (int c = 0; c < rtpm_pkg::CHANNELS; c++) begin
                loss_q[c] <= rms_q[c] <= cfg_i.min_rms;
              end
              state_q <= ST_CSTART;
            end else begin
              state_q <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          prod_q  <= cmd_q.smp[ch_q] * cmd_q.smp[ch_q];
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (cmd_q.acc[ch_q]) begin
            sum_q[ch_q] <= sum_sat;
            cnt_q[ch_q] <= cnt_q[ch_q] + rtpm_pkg::CNT_W'(1);
          end
          if (ch_q == rtpm_pkg::LAST_CH) begin
            state_q <= ST_OUT;
          end else begin
            ch_q    <= ch_q + rtpm_pkg::CH_W'(1);
            state_q <= ST_SQ;
          end
        end
        ST_CSTART: begin
          state_q <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (calc_rsp_i.done) begin
            rms_q[ch_q] <= calc_rsp_i.rms;
            sum_q[ch_q] <= '0;
            cnt_q[ch_q] <= '0;
            if (ch_q == rtpm_pkg::LAST_CH) begin
              state_q <= ST_OUT;
            end else begin
              ch_q    <= ch_q + rtpm_pkg::CH_W'(1);
              state_q <= ST_CSTART;
            end
          end
        end
        ST_OUT: begin
          // Load the result once the register is free or being emptied.
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            for (int c = 0; c < rtpm_pkg::CHANNELS; c++) begin
              out_rms_q[c] <= rms_q[c];
            end
            out_loss_q <= loss_q;
            out_rev_q  <= cmd_q.rev;
            out_done_q <= cmd_q.close;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/three_phase_rms_monitor.sv =====
// Top level of the three-phase RMS, phase-loss and phase-sequence monitor.
//
// Words arrive on in_i, one per timer tick, with valid/ready: three ADC samples
// and a phase timer count. Each accepted word gives exactly one result word on
// out_o: the latest RMS values in centivolts, the loss flags, the reversal flag
// and a flag that marks the tick which closed a window. The six registers are
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// The back end squares and adds a tick's channels one after another through its
// one squaring multiplier, and takes the next tick only once the last one is in
// the result register. A tick that closes a window sends each channel with
// samples through a long division, a square root, scaling and rounding, and a
// hand-over; an empty channel skips these steps and is answered at once.
// A two-word queue sits between the classifying front end and the back end, and
// the result register lets one result wait while the next word is worked on.
// If the receiver stalls, the back end holds its finished word, the queue
// fills and in_i.ready drops once it is full.
// Reset clears the tick counter, sums, counts, RMS values and loss flags and
// loads the registers with their defaults; no clearing pass is needed.
module three_phase_rms_monitor #(
  parameter int ADC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rtpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rtpm_pkg::WORD_W-1:0]      cfg_data_i,
  rtpm_in_if.sink                          in_i,
  rtpm_out_if.source                       out_o
);

  rtpm_pkg::cfg_t      cfg_q;
  logic                push_valid, push_ready;
  rtpm_pkg::cmd_t      push_data;
  logic                pop_valid, pop_ready;
  rtpm_pkg::cmd_t      pop_data;
  rtpm_pkg::calc_req_t calc_req;
  rtpm_pkg::calc_rsp_t calc_rsp;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len <= rtpm_pkg::WLEN_W'(80);
      cfg_q.adc_offset <= '0;
      cfg_q.volt_scale <= rtpm_pkg::WORD_W'(256);
      cfg_q.min_rms    <= '0;
      cfg_q.rev_low    <= '0;
      cfg_q.rev_high   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtpm_pkg::CFG_WINDOW_LEN: cfg_q.window_len <= cfg_data_i[rtpm_pkg::WLEN_W-1:0];
        rtpm_pkg::CFG_ADC_OFFSET: cfg_q.adc_offset <= cfg_data_i[rtpm_pkg::OFFS_W-1:0];
        rtpm_pkg::CFG_VOLT_SCALE: cfg_q.volt_scale <= cfg_data_i;
        rtpm_pkg::CFG_MIN_RMS:    cfg_q.min_rms    <= cfg_data_i;
        rtpm_pkg::CFG_REV_LOW:    cfg_q.rev_low    <= cfg_data_i;
        rtpm_pkg::CFG_REV_HIGH:   cfg_q.rev_high   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: window counter and tick classification.
  rtpm_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Command queue.
  rtpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: accumulation, window close and result register.
  rtpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .calc_req_o  (calc_req),
    .calc_rsp_i  (calc_rsp),
    .out_o       (out_o)
  );

  // Shared RMS calculation unit.
  rtpm_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .volt_scale_i (cfg_q.volt_scale),
    .req_i        (calc_req),
    .rsp_o        (calc_rsp)
  );

endmodule

// ===== hdl/rtpm_checker.sv =====
// Port checker for the RMS monitor and its binding to the top level.
`include "three_phase_rms_monitor_macros.svh"

module rtpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_rms_r_i,
  input logic [15:0] out_rms_y_i,
  input logic [15:0] out_rms_b_i,
  input logic        out_loss_r_i,
  input logic        out_loss_y_i,
  input logic        out_loss_b_i,
  input logic        out_rev_i,
  input logic        out_done_i
);

  logic [2:0]  pending_q;
  logic        in_acc, out_acc;
  logic [52:0] out_word;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Whole payload of the result channel.
  assign out_word = {out_rms_r_i, out_rms_y_i, out_rms_b_i, out_loss_r_i, out_loss_y_i,
                     out_loss_b_i, out_rev_i, out_done_i};

  // Words accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // No result is offered straight out of reset.
  `RTPM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_i)

  // A result is offered only for a word that was accepted.
  `RTPM_ASSERT(a_no_invented, out_valid_i |-> pending_q != 3'd0)

  // Queue, back end and result register hold at most four words between them.
  `RTPM_ASSERT(a_bounded, pending_q <= 3'd4)

  // A stalled result holds its payload.
  `RTPM_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word))

endmodule

bind three_phase_rms_monitor rtpm_checker u_rtpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_rms_r_i  (out_o.rms_r),
  .out_rms_y_i  (out_o.rms_y),
  .out_rms_b_i  (out_o.rms_b),
  .out_loss_r_i (out_o.loss_r),
  .out_loss_y_i (out_o.loss_y),
  .out_loss_b_i (out_o.loss_b),
  .out_rev_i    (out_o.reversal),
  .out_done_i   (out_o.window_done)
);

// ===== verif/tb_three_phase_rms_monitor.sv =====
// Testbench for the three-phase RMS monitor: directed and random ticks checked by a predictor.
module tb_three_phase_rms_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS      = rtpm_pkg::CHANNELS;
  localparam int CFG_IDX_W     = rtpm_pkg::CFG_IDX_W;
  localparam int WORD_W        = rtpm_pkg::WORD_W;
  localparam int WLEN_W        = rtpm_pkg::WLEN_W;
  localparam int OFFS_W        = rtpm_pkg::OFFS_W;
  localparam int CNT_W         = rtpm_pkg::CNT_W;
  localparam int SUM_W         = rtpm_pkg::SUM_W;

  localparam int ADC_W         = 12;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_TICKS  = 550;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 200;
  localparam int WATCHDOG_NS   = 4_000_000;

  // Indexes that select no register at all.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;

  localparam logic [63:0] SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

  // Channel 0 is R, 1 is Y and 2 is B.
  typedef struct packed {
    logic [CHANNELS-1:0][ADC_W-1:0] smp;
    logic [15:0]                    phase;
  } tick_t;

  typedef struct packed {
    logic [CHANNELS-1:0][WORD_W-1:0] rms;
    logic [CHANNELS-1:0]             loss;
    logic                            reversal;
    logic                            window_done;
  } reading_t;

  // How a channel behaves for the length of one random phase.
  typedef enum int {CH_FULL, CH_DEAD, CH_EDGE, CH_EXTREME} chan_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  rtpm_in_if #(.ADC_BITS(ADC_W)) tick_if ();
  rtpm_out_if                    reading_if ();

  three_phase_rms_monitor #(
    .ADC_BITS(ADC_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (tick_if),
    .out_o     (reading_if)
  );

  // Register copies held by the predictor.
  logic [WLEN_W-1:0] set_window;
  logic [OFFS_W-1:0] set_offset;
  logic [15:0]       set_scale;
  logic [15:0]       set_min_rms;
  logic [15:0]       set_rev_low;
  logic [15:0]       set_rev_high;

  // Predicted accumulator state.
  logic [CNT_W-1:0]  tick_count;
  logic [SUM_W-1:0]  sq_sum    [CHANNELS];
  logic [CNT_W-1:0]  smp_count [CHANNELS];
  logic [15:0]       rms_now   [CHANNELS];
  logic              loss_now  [CHANNELS];

  tick_t      pending_ticks[$];
  reading_t   expected_readings[$];
  tick_t      offered;
  logic       tick_offered = 1'b0;
  chan_mode_e chan_mode [CHANNELS];
  string      ch_name [CHANNELS] = '{"r", "y", "b"};

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          mismatches = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  logic        hold_used = 1'b0;
  reading_t    want_rd;
  reading_t    got_rd;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Register and accumulator values after reset.
  function automatic void clear_model();
    set_window   = 10'd80;
    set_offset   = '0;
    set_scale    = 16'd256;
    set_min_rms  = '0;
    set_rev_low  = '0;
    set_rev_high = 16'hFFFF;
    tick_count   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sq_sum[c]    = '0;
      smp_count[c] = '0;
      rms_now[c]   = '0;
      loss_now[c]  = 1'b0;
    end
  endfunction

  // Largest root whose square does not exceed v; v stays below 2^56.
  function automatic logic [27:0] root_floor(input logic [63:0] v);
    logic [27:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 27; i >= 0; i--) begin
      trial = 64'(r | (28'd1 << i));
      if (trial * trial <= v) r[i] = 1'b1;
    end
    return r;
  endfunction

  // Mean square in Q.16, root in Q.8, scaled to centivolts with rounding and saturation.
  function automatic logic [15:0] channel_centivolts(input logic [SUM_W-1:0] sum,
                                                     input logic [CNT_W-1:0] n);
    logic [63:0] mean_sq;
    logic [63:0] scaled;
    if (n == '0) return '0;
    mean_sq = {8'b0, sum, 16'b0} / 64'(n);
    scaled  = (64'(root_floor(mean_sq)) * 64'(set_scale) + 64'd32768) >> 16;
    return (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  // Advances the predicted state by one tick and returns the reading it produces.
  function automatic reading_t advance_tick(input tick_t t);
    reading_t    rd;
    logic [63:0] grown;
    tick_count = tick_count + CNT_W'(1);
    if (tick_count <= CNT_W'(set_window)) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (t.smp[c] > set_offset) begin
          grown        = 64'(sq_sum[c]) + 64'(t.smp[c]) * 64'(t.smp[c]);
          sq_sum[c]    = (grown > SUM_CEIL) ? SUM_CEIL[SUM_W-1:0] : grown[SUM_W-1:0];
          smp_count[c] = smp_count[c] + CNT_W'(1);
        end
      end
    end
    rd.reversal    = !(t.phase > set_rev_low && t.phase < set_rev_high);
    rd.window_done = (tick_count > CNT_W'(set_window));
    // Loss is judged on the values from the previous window, before they are replaced.
    if (rd.window_done) begin
      tick_count = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        loss_now[c]  = (rms_now[c] <= set_min_rms);
        rms_now[c]   = channel_centivolts(sq_sum[c], smp_count[c]);
        sq_sum[c]    = '0;
        smp_count[c] = '0;
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      rd.rms[c]  = rms_now[c];
      rd.loss[c] = loss_now[c];
    end
    return rd;
  endfunction

  function automatic void push_tick(input logic [ADC_W-1:0] r, input logic [ADC_W-1:0] y,
                                    input logic [ADC_W-1:0] b, input logic [15:0] pc);
    tick_t tk;
    tk.smp[0] = r;
    tk.smp[1] = y;
    tk.smp[2] = b;
    tk.phase  = pc;
    pending_ticks.push_back(tk);
  endfunction

  function automatic logic [ADC_W-1:0] random_sample(input chan_mode_e mode);
    int v;
    case (mode)
      CH_DEAD:    v = (set_offset == '0) ? 0 : int'($urandom_range(set_offset));
      CH_EDGE:    v = int'(set_offset) + int'($urandom_range(4)) - 2;
      CH_EXTREME: v = ($urandom_range(1) != 0) ? 4095 : 0;
      default:    v = int'($urandom_range(4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[ADC_W-1:0];
  endfunction

  // Phase counts cluster around both bounds so that the open interval is probed at its edges.
  function automatic logic [15:0] random_phase();
    int v;
    case ($urandom_range(3))
      0:       v = int'(set_rev_low) + int'($urandom_range(2)) - 1;
      1:       v = int'(set_rev_high) + int'($urandom_range(2)) - 1;
      default: v = int'($urandom_range(65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic void push_random_tick();
    tick_t tk;
    for (int c = 0; c < CHANNELS; c++) tk.smp[c] = random_sample(chan_mode[c]);
    tk.phase = random_phase();
    pending_ticks.push_back(tk);
  endfunction

  function automatic void pick_modes();
    for (int c = 0; c < CHANNELS; c++) begin
      chan_mode[c] = ($urandom_range(9) < 5) ? CH_FULL : chan_mode_e'($urandom_range(3, 1));
    end
  endfunction

  // One register write per clock; the enable stays high across back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      rtpm_pkg::CFG_WINDOW_LEN: set_window   = data[WLEN_W-1:0];
      rtpm_pkg::CFG_ADC_OFFSET: set_offset   = data[OFFS_W-1:0];
      rtpm_pkg::CFG_VOLT_SCALE: set_scale    = data;
      rtpm_pkg::CFG_MIN_RMS:    set_min_rms  = data;
      rtpm_pkg::CFG_REV_LOW:    set_rev_low  = data;
      rtpm_pkg::CFG_REV_HIGH:   set_rev_high = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] win, input logic [15:0] off,
                               input logic [15:0] scale, input logic [15:0] floor_rms,
                               input logic [15:0] lo, input logic [15:0] hi);
    write_reg(rtpm_pkg::CFG_WINDOW_LEN, win);
    write_reg(rtpm_pkg::CFG_ADC_OFFSET, off);
    write_reg(rtpm_pkg::CFG_VOLT_SCALE, scale);
    write_reg(rtpm_pkg::CFG_MIN_RMS, floor_rms);
    write_reg(rtpm_pkg::CFG_REV_LOW, lo);
    write_reg(rtpm_pkg::CFG_REV_HIGH, hi);
  endtask

  task automatic pick_settings();
    logic [15:0] win;
    logic [15:0] off;
    logic [15:0] scale;
    logic [15:0] floor_rms;
    logic [15:0] lo;
    logic [15:0] hi;
    case ($urandom_range(3))
      0:       win = 16'($urandom_range(4, 1));
      1:       win = 16'($urandom_range(16, 5));
      2:       win = 16'($urandom_range(64, 17));
      default: win = 16'($urandom_range(120, 65));
    endcase
    case ($urandom_range(4))
      0:       off = 16'd0;
      1:       off = 16'd4095;
      2:       off = 16'($urandom_range(4095));
      default: off = 16'($urandom_range(1500));
    endcase
    case ($urandom_range(4))
      0:       scale = 16'd0;
      1:       scale = 16'hFFFF;
      2:       scale = 16'd256;
      default: scale = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      0:       floor_rms = 16'd0;
      1:       floor_rms = 16'hFFFF;
      default: floor_rms = 16'($urandom_range(4095));
    endcase
    // Open window, ordinary window, arbitrary (possibly inverted) bounds, or an empty window.
    case ($urandom_range(3))
      0: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      1: begin
        lo = 16'($urandom_range(30000));
        hi = lo + 16'($urandom_range(30000, 2));
      end
      2: begin
        lo = 16'($urandom_range(65535));
        hi = 16'($urandom_range(65535));
      end
      default: begin
        lo = 16'($urandom_range(65535));
        hi = lo;
      end
    endcase
    load_settings(win, off, scale, floor_rms, lo, hi);
  endtask

  // Waits until every queued word has been taken and every reading has come back.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_offered || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Sender: offers queued words, idling at random, and predicts each word once it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        expected_readings.push_back(advance_tick(offered));
        tick_offered = 1'b0;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered      = pending_ticks.pop_front();
          tick_offered = 1'b1;
          tick_if.valid       <= 1'b1;
          tick_if.sample_r    <= offered.smp[0];
          tick_if.sample_y    <= offered.smp[1];
          tick_if.sample_b    <= offered.smp[2];
          tick_if.phase_count <= offered.phase;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each reading against the oldest prediction and drives ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reading_if.ready <= 1'b0;
    end else begin
      if (reading_if.valid && reading_if.ready) begin
        results_seen++;
        for (int c = 0; c < CHANNELS; c++) begin
          got_rd.rms[c] = (c == 0) ? reading_if.rms_r :
                          (c == 1) ? reading_if.rms_y : reading_if.rms_b;
          got_rd.loss[c] = (c == 0) ? reading_if.loss_r :
                           (c == 1) ? reading_if.loss_y : reading_if.loss_b;
        end
        got_rd.reversal    = reading_if.reversal;
        got_rd.window_done = reading_if.window_done;
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: reading word with no prediction waiting, expected none, actual %h",
                   $time, got_rd);
        end else begin
          want_rd = expected_readings.pop_front();
          for (int c = 0; c < CHANNELS; c++) begin
            report_field({"rms_", ch_name[c]}, want_rd.rms[c], got_rd.rms[c]);
            report_field({"loss_", ch_name[c]}, 16'(want_rd.loss[c]), 16'(got_rd.loss[c]));
          end
          report_field("reversal", 16'(want_rd.reversal), 16'(got_rd.reversal));
          report_field("window_done", 16'(want_rd.window_done), 16'(got_rd.window_done));
        end
      end
      // One long hold-off while the sender still has plenty queued, so the block backs up.
      if (hold_left != 0) begin
        hold_left--;
        reading_if.ready <= 1'b0;
      end else if (!hold_used && results_seen >= HOLD_AFTER && pending_ticks.size() > 8) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        reading_if.ready <= 1'b0;
      end else begin
        reading_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus: directed corner cases first, then random phases under changing settings.
  initial begin
    int placed;
    int n;
    int ph;
    clear_model();
    cfg_we_i            = 1'b0;
    cfg_idx_i           = rtpm_pkg::CFG_WINDOW_LEN;
    cfg_data_i          = '0;
    tick_if.valid       = 1'b0;
    tick_if.sample_r    = '0;
    tick_if.sample_y    = '0;
    tick_if.sample_b    = '0;
    tick_if.phase_count = '0;
    reading_if.ready    = 1'b0;
    send_idle_pct       = 36;
    recv_idle_pct       = 79;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short windows; Y stays empty in the first window, phase counts sit on both bounds.
    load_settings(16'd3, 16'd0, 16'd256, 16'd0, 16'd100, 16'd200);
    write_reg(SPARE_IDX_A, 16'hFFFF);
    write_reg(SPARE_IDX_B, 16'hFFFF);
    end_writes();
    push_tick(12'd4095, 12'd0, 12'd2048, 16'd0);
    push_tick(12'd4095, 12'd0, 12'd1, 16'd100);
    push_tick(12'd4095, 12'd0, 12'd4094, 16'd101);
    push_tick(12'd0, 12'd0, 12'd0, 16'd199);
    push_tick(12'd1, 12'd1, 12'd1, 16'd200);
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd65535);
    push_tick(12'd2730, 12'd1365, 12'd3000, 16'd150);
    push_tick(12'd0, 12'd0, 12'd0, 16'd65534);
    wait_idle();

    // A high loss threshold flags every channel at the next window end.
    write_reg(rtpm_pkg::CFG_MIN_RMS, 16'd4095);
    end_writes();
    push_tick(12'd1000, 12'd0, 12'd4095, 16'd150);
    push_tick(12'd1000, 12'd0, 12'd4095, 16'd150);
    push_tick(12'd1000, 12'd0, 12'd4095, 16'd150);
    push_tick(12'd1000, 12'd0, 12'd4095, 16'd150);
    wait_idle();

    // Every sample at or below the offset: all channels close empty.
    write_reg(rtpm_pkg::CFG_ADC_OFFSET, 16'd4095);
    end_writes();
    repeat (4) push_tick(12'd4095, 12'd4095, 12'd4095, 16'd120);
    wait_idle();

    // A window shortened part-way through closes on the next tick.
    write_reg(rtpm_pkg::CFG_WINDOW_LEN, 16'd20);
    write_reg(rtpm_pkg::CFG_ADC_OFFSET, 16'd0);
    end_writes();
    repeat (5) push_tick(12'd3000, 12'd2000, 12'd1000, 16'd150);
    wait_idle();
    write_reg(rtpm_pkg::CFG_WINDOW_LEN, 16'd2);
    end_writes();
    push_tick(12'd500, 12'd600, 12'd700, 16'd150);
    push_tick(12'd500, 12'd600, 12'd700, 16'd150);
    wait_idle();

    // Window length zero: every tick closes a window and nothing is summed.
    write_reg(rtpm_pkg::CFG_WINDOW_LEN, 16'd0);
    end_writes();
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd150);
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd150);
    wait_idle();

    // Largest scale saturates the result; the phase window is open from 0 to 65535.
    load_settings(16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    end_writes();
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd65535);
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd0);
    push_tick(12'd4095, 12'd4095, 12'd4095, 16'd1);
    wait_idle();

    // Random phases, each under its own settings and channel behaviour.
    placed = 0;
    ph     = 0;
    while (placed < RANDOM_TICKS) begin
      if (placed < RANDOM_TICKS / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 79;
      end else if (placed < 2 * RANDOM_TICKS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_modes();
      if (ph == 0) begin
        load_settings(16'd80, 16'd0, 16'd256, 16'd0, 16'd0, 16'hFFFF);
        n = 90;
      end else if (ph == 3) begin
        load_settings(16'd1023, 16'($urandom_range(1000)), 16'($urandom_range(65535)),
                      16'($urandom_range(4095)), 16'd0, 16'hFFFF);
        n = 200;
      end else begin
        pick_settings();
        n = $urandom_range(70, 30);
      end
      end_writes();
      repeat (n) push_random_tick();
      placed += n;
      wait_idle();
      // The longest window is cut short so that it closes within the run.
      if (ph == 3) begin
        write_reg(rtpm_pkg::CFG_WINDOW_LEN, 16'd150);
        end_writes();
        repeat (20) push_random_tick();
        placed += 20;
        wait_idle();
      end
      ph++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rtpm_pkg.sv
hdl/rtpm_in_if.sv
hdl/rtpm_out_if.sv
hdl/rtpm_front.sv
hdl/rtpm_queue.sv
hdl/rtpm_calc.sv
hdl/rtpm_back.sv
hdl/three_phase_rms_monitor.sv
hdl/rtpm_checker.sv
verif/tb_three_phase_rms_monitor.sv
